// ===== hdl/mlrq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared types, codes and sizes for the multilevel ready-queue scheduler.
// ----------------------------------------------------------------------------
package mlrq_pkg;

   // default sizes
   localparam int NUM_LEVELS_DEF  = 4;
   localparam int LEVEL_DEPTH_DEF = 8;
   localparam int ID_COUNT_DEF    = 256;

   // a dispatch gives at most this many results, all but the last reaped, before giving up
   localparam int MAX_RESULTS = 33;
   localparam int DRAIN_CAP   = MAX_RESULTS - 1;
   localparam int DRAIN_W     = $clog2(MAX_RESULTS);

   // stream widths
   localparam int REQ_DATA_W = 24;  // task_id, level, slice_len, already_killed
   localparam int REQ_USER_W = 2;   // mode
   localparam int RSP_DATA_W = 24;  // out_id, out_level, ticks_left
   localparam int RSP_USER_W = 3;   // status

   localparam int ID_W    = 8;
   localparam int LEVEL_W = 3;
   localparam int SLICE_W = 8;
   localparam int OLVL_W  = 2;
   localparam int ENTRY_W = ID_W + SLICE_W;

   // request modes
   localparam logic [1:0] MODE_SCHED    = 2'd0;
   localparam logic [1:0] MODE_DISPATCH = 2'd1;
   localparam logic [1:0] MODE_KILL     = 2'd2;

   // result status codes
   localparam logic [2:0] ST_QUEUED     = 3'd0;
   localparam logic [2:0] ST_REAPED     = 3'd1;
   localparam logic [2:0] ST_DISPATCHED = 3'd2;
   localparam logic [2:0] ST_BAD_LEVEL  = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_NONE_READY = 3'd5;
   localparam logic [2:0] ST_KILL_MARK  = 3'd6;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;  // clear one killed mark of the post-reset pass
      logic load_req;    // capture the accepted request, read its mark
      logic exec_item;   // carry out schedule / kill and emit its result
      logic scan_pop;    // pop head of first ready level, start store read
      logic mark_read;   // read the killed mark of the popped entry
      logic emit_none;   // emit the none-ready result
      logic check_emit;  // emit reaped or dispatched for the popped entry
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] mode;
      logic       any_ready;
      logic       slot_free;
      logic       head_killed;
      logic       clear_last;
   } sts_type;

endpackage

// ===== hdl/mlrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlrq_ctrl
// Sequencer: takes one request at a time and steps the datapath through
// schedule, kill or the dispatch drain loop.
// ----------------------------------------------------------------------------
module mlrq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  mlrq_pkg::sts_type sts,
   output mlrq_pkg::cmd_type cmd
);
   import mlrq_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_MARK  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;

   always_comb begin
      state_in   = state_ff;
      drain_in   = drain_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.mode)
               MODE_SCHED, MODE_KILL: begin
                  if (sts.slot_free) begin
                     cmd.exec_item = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               MODE_DISPATCH: begin
                  drain_in = '0;
                  state_in = S_SCAN;
               end
               default: state_in = S_IDLE;  // unused mode: no result
            endcase
         end
         S_SCAN: begin
            if (drain_ff == DRAIN_W'(DRAIN_CAP) || !sts.any_ready) begin
               if (sts.slot_free) begin
                  cmd.emit_none = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.scan_pop = 1'b1;
               state_in     = S_MARK;
            end
         end
         S_MARK: begin
            cmd.mark_read = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (sts.slot_free) begin
               cmd.check_emit = 1'b1;
               if (sts.head_killed) begin
                  drain_in = drain_ff + DRAIN_W'(1);
                  state_in = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

endmodule

// ===== hdl/mlrq_dp.sv =====
// ----------------------------------------------------------------------------
// mlrq_dp
// Datapath: request register, per-level ring pointers and fill counts,
// entry store, killed marks and the result register.
// ----------------------------------------------------------------------------
module mlrq_dp #(
   parameter int NUM_LEVELS  = mlrq_pkg::NUM_LEVELS_DEF,
   parameter int LEVEL_DEPTH = mlrq_pkg::LEVEL_DEPTH_DEF,
   parameter int ID_COUNT    = mlrq_pkg::ID_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mlrq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [mlrq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mlrq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [mlrq_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   input  mlrq_pkg::cmd_type               cmd,
   output mlrq_pkg::sts_type               sts
);
   import mlrq_pkg::*;

   localparam int LW     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PW     = $clog2(LEVEL_DEPTH);
   localparam int CW     = $clog2(LEVEL_DEPTH + 1);
   localparam int DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
   localparam int AW     = $clog2(DEPTH);
   // ids are 8 bits wide, so no more than 256 marks can ever be reached
   localparam int KILL_N = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
   localparam int KW     = $clog2(KILL_N);

   // request register
   logic [1:0]         mode_ff;
   logic [ID_W-1:0]    id_ff;
   logic [LEVEL_W-1:0] lvl_ff;
   logic [SLICE_W-1:0] slice_ff;
   logic               dead_ff;

   // queue control
   logic [PW-1:0] head_ff [NUM_LEVELS];
   logic [PW-1:0] tail_ff [NUM_LEVELS];
   logic [CW-1:0] fill_ff [NUM_LEVELS];
   logic [PW-1:0] head_in [NUM_LEVELS];
   logic [PW-1:0] tail_in [NUM_LEVELS];
   logic [CW-1:0] fill_in [NUM_LEVELS];

   // killed marks, cleared by a pass after reset
   logic               kill_mem [KILL_N];
   logic               kill_rd_ff;
   logic [KW-1:0]      clr_ptr_ff, clr_ptr_in;
   logic               kw_en;
   logic               kw_data;
   logic [KW-1:0]      kw_addr;
   logic [ID_W-1:0]    kr_id;

   // entry store
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [LEVEL_W-1:0] pop_lvl_ff, pop_lvl_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [2:0]         out_status_ff, out_status_in;
   logic [ID_W-1:0]    out_id_ff, out_id_in;
   logic [OLVL_W-1:0]  out_level_ff, out_level_in;
   logic [SLICE_W-1:0] out_ticks_ff, out_ticks_in;
   logic               out_last_ff, out_last_in;
   logic               emit;

   logic [LW-1:0] pick_lvl;
   logic          any_ready;
   logic [LW-1:0] req_lvl;
   logic          lvl_ok;
   logic          slot_free;
   logic [ID_W-1:0]    head_id;
   logic [SLICE_W-1:0] head_slice;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (32'(p) == LEVEL_DEPTH - 1) ? '0 : p + PW'(1);
      return r;
   endfunction

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign lvl_ok     = 32'(lvl_ff) < NUM_LEVELS;
   assign req_lvl    = LW'(lvl_ff);
   assign head_id    = rd_data_ff[ID_W-1:0];
   assign head_slice = rd_data_ff[ENTRY_W-1:ID_W];
   // mark lookup: the incoming id on accept, the popped id during a drain
   assign kr_id      = cmd.mark_read ? head_id : req_tdata[ID_W-1:0];

   // first non-empty level, 0 wins
   always_comb begin
      pick_lvl  = '0;
      any_ready = 1'b0;
      for (int n = NUM_LEVELS - 1; n >= 0; n--) begin
         if (fill_ff[n] != '0) begin
            pick_lvl  = LW'(n);
            any_ready = 1'b1;
         end
      end
   end

   assign sts.mode        = mode_ff;
   assign sts.any_ready   = any_ready;
   assign sts.slot_free   = slot_free;
   assign sts.head_killed = kill_rd_ff;
   assign sts.clear_last  = (32'(clr_ptr_ff) == KILL_N - 1);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      clr_ptr_in    = clr_ptr_ff;
      kw_en         = 1'b0;
      kw_data       = 1'b0;
      kw_addr       = id_ff[KW-1:0];
      wr_en         = 1'b0;
      wr_addr       = AW'(int'(req_lvl) * LEVEL_DEPTH + int'(tail_ff[req_lvl]));
      rd_addr       = AW'(int'(pick_lvl) * LEVEL_DEPTH + int'(head_ff[pick_lvl]));
      pop_lvl_in    = pop_lvl_ff;
      emit          = 1'b0;
      out_status_in = out_status_ff;
      out_id_in     = out_id_ff;
      out_level_in  = out_level_ff;
      out_ticks_in  = out_ticks_ff;
      out_last_in   = out_last_ff;

      if (cmd.clear_step) begin
         kw_en      = 1'b1;
         kw_addr    = clr_ptr_ff;
         clr_ptr_in = clr_ptr_ff + KW'(1);
      end

      if (cmd.exec_item) begin
         emit         = 1'b1;
         out_id_in    = id_ff;
         out_level_in = '0;
         out_ticks_in = '0;
         out_last_in  = 1'b1;
         if (mode_ff == MODE_KILL) begin
            out_status_in = ST_KILL_MARK;
            if (32'(id_ff) < ID_COUNT) begin
               kw_en   = 1'b1;
               kw_data = 1'b1;
            end
         end else if (dead_ff || kill_rd_ff) begin
            out_status_in = ST_REAPED;
            if (32'(id_ff) < ID_COUNT) kw_en = 1'b1;
         end else if (!lvl_ok) begin
            out_status_in = ST_BAD_LEVEL;
         end else if (32'(fill_ff[req_lvl]) >= LEVEL_DEPTH) begin
            out_status_in = ST_FULL;
            out_level_in  = lvl_ff[OLVL_W-1:0];
         end else begin
            out_status_in    = ST_QUEUED;
            out_level_in     = lvl_ff[OLVL_W-1:0];
            wr_en            = 1'b1;
            tail_in[req_lvl] = wrap_inc(tail_ff[req_lvl]);
            fill_in[req_lvl] = fill_ff[req_lvl] + CW'(1);
         end
      end

      if (cmd.scan_pop) begin
         head_in[pick_lvl] = wrap_inc(head_ff[pick_lvl]);
         fill_in[pick_lvl] = fill_ff[pick_lvl] - CW'(1);
         pop_lvl_in        = LEVEL_W'(pick_lvl);
      end

      if (cmd.emit_none) begin
         emit          = 1'b1;
         out_status_in = ST_NONE_READY;
         out_id_in     = '0;
         out_level_in  = '0;
         out_ticks_in  = '0;
         out_last_in   = 1'b1;
      end

      if (cmd.check_emit) begin
         emit         = 1'b1;
         out_id_in    = head_id;
         out_level_in = pop_lvl_ff[OLVL_W-1:0];
         if (kill_rd_ff) begin
            out_status_in = ST_REAPED;
            out_ticks_in  = '0;
            out_last_in   = 1'b0;
            kw_en         = 1'b1;
            kw_addr       = head_id[KW-1:0];
         end else begin
            out_status_in = ST_DISPATCHED;
            out_ticks_in  = head_slice;
            out_last_in   = 1'b1;
         end
      end

      if (emit)            out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      else                 out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= req_tuser;
         id_ff    <= req_tdata[7:0];
         lvl_ff   <= req_tdata[10:8];
         slice_ff <= req_tdata[18:11];
         dead_ff  <= req_tdata[19];
      end
      pop_lvl_ff    <= pop_lvl_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
      out_level_ff  <= out_level_in;
      out_ticks_ff  <= out_ticks_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= {slice_ff, id_ff};
      if (cmd.scan_pop) rd_data_ff <= mem[rd_addr];
   end

   // ids at or beyond ID_COUNT read as not killed
   always_ff @(posedge clock) begin
      if (kw_en) kill_mem[kw_addr] <= kw_data;
      if (cmd.load_req || cmd.mark_read)
         kill_rd_ff <= (32'(kr_id) < ID_COUNT) ? kill_mem[kr_id[KW-1:0]] : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_LEVELS; n++) begin
            head_ff[n] <= '0;
            tail_ff[n] <= '0;
            fill_ff[n] <= '0;
         end
         clr_ptr_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         clr_ptr_ff   <= clr_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ticks_ff, out_level_ff, out_id_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hdl/multilevel_ready_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_top
// Multilevel priority ready-queue scheduler: schedule, dispatch, kill marks.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                         | tuser  | tlast
//  req_    | in        | task_id, level, slice_len, already_killed  | mode   | -
//  rsp_    | out       | out_id, out_level, ticks_left              | status | last
//
//  One request at a time. Schedule and kill finish in the execute state. A
//  dispatch pops one entry per pass (registered store read, then registered
//  mark read) and ends with a dispatched or a none-ready result, after
//  reaping up to 32 killed tasks.
//  A result register sits on rsp_; a stalled rsp_tready holds the sequencer
//  only when it has a further result to hand over.
//  Reset (synchronous) empties all levels; the killed marks are then cleared
//  one per cycle while req_tready stays low.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_top #(
   parameter int NUM_LEVELS  = mlrq_pkg::NUM_LEVELS_DEF,
   parameter int LEVEL_DEPTH = mlrq_pkg::LEVEL_DEPTH_DEF,
   parameter int ID_COUNT    = mlrq_pkg::ID_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // task_id[7:0], level[10:8], slice_len[18:11], already_killed[19]
   input  logic [mlrq_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [mlrq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_id[7:0], out_level[9:8], ticks_left[17:10]
   output logic [mlrq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [mlrq_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import mlrq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mlrq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mlrq_dp #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .ID_COUNT    (ID_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
